>>> src/eraa_pkg.sv
package eraa_pkg;

   // Field widths
   localparam int PRICE_W    = 32;
   localparam int FRAC_W     = 16;
   localparam int AVG_W      = PRICE_W + FRAC_W;
   localparam int LIMIT_W    = 16;
   localparam int ER_W       = LIMIT_W + 1;
   localparam int CSR_IDX_W  = 2;

   localparam int WINDOW_DEF = 10;

   // Limit clamps and reset values, Q0.16; ER_ONE is 1.0 in Q1.16
   localparam logic [LIMIT_W-1:0] FAST_MIN   = 16'd655;
   localparam logic [LIMIT_W-1:0] FAST_MAX   = 16'd64880;
   localparam logic [LIMIT_W-1:0] SLOW_MIN   = 16'd66;
   localparam logic [LIMIT_W-1:0] FAST_RESET = 16'd32768;
   localparam logic [LIMIT_W-1:0] SLOW_RESET = 16'd3277;
   localparam logic [ER_W-1:0]    ER_ONE     = 17'h10000;

   // Serial datapath: signed difference, accumulator, radix-4 digits, divider steps
   localparam int D_W        = AVG_W + 1;
   localparam int ACC_W      = D_W + 4;
   localparam int W_SR_W     = 18;
   localparam int MUL_STEPS  = W_SR_W / 2;
   localparam int DIV_STEPS  = LIMIT_W;
   localparam int STEP_W     = 5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FAST_LIMIT = 2'd0,
      CSR_SLOW_LIMIT = 2'd1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SUM,
      ST_DIV_SET,
      ST_DIV,
      ST_ALPHA,
      ST_MUL_SET,
      ST_MUL,
      ST_MUL_END,
      ST_DONE
   } state_type;

endpackage

>>> src/efficiency_ratio_adaptive_average_unit.sv
// Takes one bar at a time: req_stall stays high from the input transfer until the result
//   is written to the result register, which waits while an earlier result is stalled.
// The work is set by the 16-step restoring divider and two 9-step radix-4 multiplies on
//   one sequencer; a zero or saturated ratio skips the division, a first or restart bar both.
// Reset (synchronous, active high) returns the limits to 0.5 / 0.05, drops the series
//   and empties the result register; history memory needs no clearing pass.
module efficiency_ratio_adaptive_average_unit #(
   parameter int WINDOW = eraa_pkg::WINDOW_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [eraa_pkg::PRICE_W-1:0]       req_close_price,
   input  logic                               req_restart,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [eraa_pkg::AVG_W-1:0]         rsp_adaptive_average,
   output logic [eraa_pkg::AVG_W-1:0]         rsp_follower_average,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [eraa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [eraa_pkg::LIMIT_W-1:0]       csr_wdata
);
   import eraa_pkg::*;

   localparam int POS_W  = $clog2(WINDOW);
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int VSUM_W = PRICE_W + $clog2(WINDOW);
   localparam int MEM_W  = 2 * PRICE_W;

   // Sequencer and series state
   state_type              state_ff, state_in;
   logic                   started_ff, started_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [VSUM_W-1:0]      vsum_ff, vsum_in;
   logic [PRICE_W-1:0]     seed_ff, seed_in;
   logic [PRICE_W-1:0]     prev_ff, prev_in;
   logic [AVG_W-1:0]       adaptive_ff, adaptive_in;
   logic [AVG_W-1:0]       follower_ff, follower_in;

   // Configuration and derived limits
   logic [LIMIT_W-1:0]     fast_ff, fast_in;
   logic [LIMIT_W-1:0]     slow_ff, slow_in;
   logic [LIMIT_W-1:0]     fast_eff_ff, fast_eff_in;
   logic [LIMIT_W-1:0]     slow_eff_ff, slow_eff_in;
   logic [LIMIT_W-1:0]     diff_ff, diff_in;

   // Per-bar working registers
   logic [PRICE_W-1:0]     close_ff, close_in;
   logic                   restart_ff, restart_in;
   logic [PRICE_W-1:0]     change_ff, change_in;
   logic [PRICE_W-1:0]     delta_ff, delta_in;
   logic [VSUM_W-1:0]      rem_ff, rem_in;
   logic [LIMIT_W-1:0]     quot_ff, quot_in;
   logic [ER_W-1:0]        er_ff, er_in;
   logic [LIMIT_W-1:0]     alpha_ff, alpha_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   phase_ff, phase_in;
   logic signed [D_W-1:0]  d_ff, d_in;
   logic [W_SR_W-1:0]      w_sr_ff, w_sr_in;
   logic                   prev_bit_ff, prev_bit_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   // Result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [AVG_W-1:0]       rsp_adaptive_ff, rsp_adaptive_in;
   logic [AVG_W-1:0]       rsp_follower_ff, rsp_follower_in;

   // History memory: {delta, close} per ring slot
   logic                   ram_we;
   logic [MEM_W-1:0]       ram_wdata;
   logic [MEM_W-1:0]       ram_rdata;

   eraa_ram #(
      .WIDTH (MEM_W),
      .DEPTH (WINDOW)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (pos_ff),
      .wr_data (ram_wdata),
      .rd_addr (pos_ff),
      .rd_data (ram_rdata)
   );

   assign req_stall            = (state_ff != ST_IDLE);
   assign csr_ready            = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_adaptive_average = rsp_adaptive_ff;
   assign rsp_follower_average = rsp_follower_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         started_ff   <= 1'b0;
         pos_ff       <= '0;
         fill_ff      <= '0;
         vsum_ff      <= '0;
         adaptive_ff  <= '0;
         follower_ff  <= '0;
         fast_ff      <= FAST_RESET;
         slow_ff      <= SLOW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         pos_ff       <= pos_in;
         fill_ff      <= fill_in;
         vsum_ff      <= vsum_in;
         adaptive_ff  <= adaptive_in;
         follower_ff  <= follower_in;
         fast_ff      <= fast_in;
         slow_ff      <= slow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      seed_ff         <= seed_in;
      prev_ff         <= prev_in;
      fast_eff_ff     <= fast_eff_in;
      slow_eff_ff     <= slow_eff_in;
      diff_ff         <= diff_in;
      close_ff        <= close_in;
      restart_ff      <= restart_in;
      change_ff       <= change_in;
      delta_ff        <= delta_in;
      rem_ff          <= rem_in;
      quot_ff         <= quot_in;
      er_ff           <= er_in;
      alpha_ff        <= alpha_in;
      step_ff         <= step_in;
      phase_ff        <= phase_in;
      d_ff            <= d_in;
      w_sr_ff         <= w_sr_in;
      prev_bit_ff     <= prev_bit_in;
      acc_ff          <= acc_in;
      rsp_adaptive_ff <= rsp_adaptive_in;
      rsp_follower_ff <= rsp_follower_in;
   end

   always_comb begin
      logic                    fill_full;
      logic [PRICE_W-1:0]      ref_price;
      logic [PRICE_W-1:0]      old_delta;
      logic [PRICE_W-1:0]      delta_v;
      logic [LIMIT_W-1:0]      slow_raised;
      logic [VSUM_W:0]         rem2;
      logic [LIMIT_W-1:0]      quot_next;
      logic [LIMIT_W+ER_W-1:0] prod;
      logic [ER_W-1:0]         alpha_sum;
      logic [AVG_W-1:0]        x_v;
      logic [AVG_W-1:0]        y_v;
      logic [2:0]              digit;
      logic                    dig_neg;
      logic                    dig_one;
      logic                    dig_two;
      logic signed [ACC_W-1:0] d_ext;
      logic signed [ACC_W-1:0] mag;
      logic signed [ACC_W-1:0] addend;
      logic signed [ACC_W-1:0] acc_sum;
      logic signed [ACC_W-1:0] res_sum;

      state_in        = state_ff;
      started_in      = started_ff;
      pos_in          = pos_ff;
      fill_in         = fill_ff;
      vsum_in         = vsum_ff;
      seed_in         = seed_ff;
      prev_in         = prev_ff;
      adaptive_in     = adaptive_ff;
      follower_in     = follower_ff;
      fast_in         = fast_ff;
      slow_in         = slow_ff;
      close_in        = close_ff;
      restart_in      = restart_ff;
      change_in       = change_ff;
      delta_in        = delta_ff;
      rem_in          = rem_ff;
      quot_in         = quot_ff;
      er_in           = er_ff;
      alpha_in        = alpha_ff;
      step_in         = step_ff;
      phase_in        = phase_ff;
      d_in            = d_ff;
      w_sr_in         = w_sr_ff;
      prev_bit_in     = prev_bit_ff;
      acc_in          = acc_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_adaptive_in = rsp_adaptive_ff;
      rsp_follower_in = rsp_follower_ff;
      ram_we          = 1'b0;

      // Ring slot holds real history only once a full window has passed since the seed;
      // before that the slot stands for the seed close with no change.
      fill_full = (fill_ff == FILL_W'(WINDOW));
      ref_price = fill_full ? ram_rdata[PRICE_W-1:0] : seed_ff;
      old_delta = fill_full ? ram_rdata[MEM_W-1:PRICE_W] : '0;
      delta_v   = (close_ff >= prev_ff) ? close_ff - prev_ff : prev_ff - close_ff;
      ram_wdata = {delta_v, close_ff};

      // Clamp the limits continuously; the user must change config only while idle, the block does not enforce it
      if (fast_ff < FAST_MIN) begin
         fast_eff_in = FAST_MIN;
      end else if (fast_ff > FAST_MAX) begin
         fast_eff_in = FAST_MAX;
      end else begin
         fast_eff_in = fast_ff;
      end
      slow_raised = (slow_ff < SLOW_MIN) ? SLOW_MIN : slow_ff;
      slow_eff_in = (slow_raised > fast_eff_ff) ? fast_eff_ff : slow_raised;
      diff_in     = fast_eff_ff - slow_eff_ff;

      rem2      = {rem_ff, 1'b0};
      quot_next = {quot_ff[LIMIT_W-2:0], (rem2 >= {1'b0, vsum_ff})};

      prod      = (LIMIT_W+ER_W)'(diff_ff) * (LIMIT_W+ER_W)'(er_ff);
      alpha_sum = {1'b0, slow_eff_ff} + prod[LIMIT_W+ER_W-1:LIMIT_W];

      // Blend operands: adaptive pass, then follower pass
      if (!phase_ff) begin
         x_v = {close_ff, FRAC_W'(0)};
         y_v = adaptive_ff;
      end else begin
         x_v = adaptive_ff;
         y_v = follower_ff;
      end

      // Radix-4 recoded digit of the weight
      digit   = {w_sr_ff[1:0], prev_bit_ff};
      dig_neg = digit[2] & ~(digit[1] & digit[0]);
      dig_one = digit[1] ^ digit[0];
      dig_two = (digit[2] ^ digit[1]) & (digit[1] ~^ digit[0]);
      d_ext   = $signed({{(ACC_W-D_W){d_ff[D_W-1]}}, d_ff});
      if (dig_two) begin
         mag = d_ext <<< 1;
      end else if (dig_one) begin
         mag = d_ext;
      end else begin
         mag = '0;
      end
      addend  = dig_neg ? -mag : mag;
      acc_sum = acc_ff + addend;
      res_sum = $signed({{(ACC_W-AVG_W){1'b0}}, y_v}) + acc_ff;

      // Release the result register on transfer
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         case (csr_index)
            CSR_FAST_LIMIT: fast_in = csr_wdata;
            CSR_SLOW_LIMIT: slow_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               close_in   = req_close_price;
               restart_in = req_restart;
               state_in   = ST_FETCH;
            end
         end

         ST_FETCH: begin
            if (!started_ff || restart_ff) begin
               // First bar of a series: seed both averages, restart the ring
               seed_in     = close_ff;
               prev_in     = close_ff;
               vsum_in     = '0;
               fill_in     = '0;
               pos_in      = POS_W'(1);
               started_in  = 1'b1;
               adaptive_in = {close_ff, FRAC_W'(0)};
               follower_in = {close_ff, FRAC_W'(0)};
               state_in    = ST_DONE;
            end else begin
               change_in = (close_ff >= ref_price) ? close_ff - ref_price
                                                   : ref_price - close_ff;
               delta_in  = delta_v;
               vsum_in   = vsum_ff - VSUM_W'(old_delta);
               ram_we    = 1'b1;
               prev_in   = close_ff;
               pos_in    = (pos_ff == POS_W'(WINDOW - 1)) ? '0 : pos_ff + 1'b1;
               if (!fill_full) begin
                  fill_in = fill_ff + 1'b1;
               end
               state_in  = ST_SUM;
            end
         end

         ST_SUM: begin
            vsum_in  = vsum_ff + VSUM_W'(delta_ff);
            state_in = ST_DIV_SET;
         end

         ST_DIV_SET: begin
            if (vsum_ff == '0) begin
               er_in    = '0;
               state_in = ST_ALPHA;
            end else if (VSUM_W'(change_ff) >= vsum_ff) begin
               er_in    = ER_ONE;
               state_in = ST_ALPHA;
            end else begin
               rem_in   = VSUM_W'(change_ff);
               quot_in  = '0;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end

         ST_DIV: begin
            // One quotient bit per cycle
            if (rem2 >= {1'b0, vsum_ff}) begin
               rem_in = VSUM_W'(rem2 - {1'b0, vsum_ff});
            end else begin
               rem_in = rem2[VSUM_W-1:0];
            end
            quot_in = quot_next;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               er_in    = {1'b0, quot_next};
               state_in = ST_ALPHA;
            end
         end

         ST_ALPHA: begin
            alpha_in = alpha_sum[LIMIT_W-1:0];
            phase_in = 1'b0;
            state_in = ST_MUL_SET;
         end

         ST_MUL_SET: begin
            d_in        = $signed({1'b0, x_v}) - $signed({1'b0, y_v});
            w_sr_in     = phase_ff ? W_SR_W'(alpha_ff[LIMIT_W-1:1]) : W_SR_W'(alpha_ff);
            prev_bit_in = 1'b0;
            acc_in      = '0;
            step_in     = '0;
            state_in    = ST_MUL;
         end

         ST_MUL: begin
            // Add one digit, drop two product bits; last digit is added unshifted
            if (step_ff == STEP_W'(MUL_STEPS - 1)) begin
               acc_in   = acc_sum;
               state_in = ST_MUL_END;
            end else begin
               acc_in      = acc_sum >>> 2;
               w_sr_in     = w_sr_ff >> 2;
               prev_bit_in = w_sr_ff[1];
               step_in     = step_ff + 1'b1;
            end
         end

         ST_MUL_END: begin
            if (!phase_ff) begin
               adaptive_in = res_sum[AVG_W-1:0];
               phase_in    = 1'b1;
               state_in    = ST_MUL_SET;
            end else begin
               follower_in = res_sum[AVG_W-1:0];
               state_in    = ST_DONE;
            end
         end

         ST_DONE: begin
            // Hold until the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_adaptive_in = adaptive_ff;
               rsp_follower_in = follower_ff;
               state_in        = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> src/eraa_ram.sv
module eraa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 10
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

>>> test/efficiency_ratio_adaptive_average_unit_tb.sv
module efficiency_ratio_adaptive_average_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import eraa_pkg::*;

   localparam int CLK_HALF        = 5;
   localparam int RESET_CYCLES    = 7;
   localparam int WINDOW          = WINDOW_DEF;
   localparam int FIXED_PHASES    = 5;
   localparam int PHASE_COUNT     = 8;
   localparam int ITEMS_PER_PHASE = 166;
   localparam int DIRECTED_N      = 24;
   // Tail pad, long enough for a normal bar to finish.
   localparam int LATENCY_PAD     = 50;
   localparam int DRAIN_LIMIT     = 20000;
   // Timeout in ns for the watchdog that ends a hung run.
   localparam int TIMEOUT_NS      = 10_000_000;

   // Register indexes the block does not decode; writes to them must be ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_RSVD_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RSVD_HI = 2'd3;

   typedef struct packed {
      logic [AVG_W-1:0] adaptive;
      logic [AVG_W-1:0] follower;
   } bar_result_type;

   // One row of the directed table; known holds the result where it is
   // obvious (seed bars and flat bars at a seeded level).
   typedef struct packed {
      logic [PRICE_W-1:0] close;
      logic               restart;
      logic               typed;
      bar_result_type     known;
   } bar_row_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] fast;
      logic [LIMIT_W-1:0] slow;
      logic               steady;
   } limit_phase_type;

   // DUT ports; every input starts at a known value.
   logic                 clock           = 1'b0;
   logic                 reset           = 1'b1;
   logic                 req_valid       = 1'b0;
   logic                 req_stall;
   logic [PRICE_W-1:0]   req_close_price = '0;
   logic                 req_restart     = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall       = 1'b0;
   logic [AVG_W-1:0]     rsp_adaptive_average;
   logic [AVG_W-1:0]     rsp_follower_average;
   logic                 csr_valid       = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index       = CSR_FAST_LIMIT;
   logic [LIMIT_W-1:0]   csr_wdata       = '0;

   // Shadow of the block: limit registers and series state.
   logic [LIMIT_W-1:0]   fast_cfg = FAST_RESET;
   logic [LIMIT_W-1:0]   slow_cfg = SLOW_RESET;
   logic [PRICE_W-1:0]   close_ring [WINDOW];
   logic [PRICE_W-1:0]   move_ring  [WINDOW];
   logic [63:0]          move_sum   = '0;
   logic [63:0]          kama_acc   = '0;
   logic [63:0]          follow_acc = '0;
   bit                   series_live = 1'b0;
   int unsigned          ring_idx    = 0;

   bar_result_type       pending_results [$];
   int                   mismatch_count = 0;
   bit                   steady_flow    = 1'b0;
   int                   stall_hold     = 0;

   bar_row_type directed_rows [DIRECTED_N] = '{
      // first bar after reset seeds at zero, then stays flat at zero
      '{32'h0000_0000, 1'b0, 1'b1, '{48'h0, 48'h0}},
      '{32'h0000_0000, 1'b0, 1'b1, '{48'h0, 48'h0}},
      // full-scale swings
      '{32'hFFFF_FFFF, 1'b0, 1'b0, '0},
      '{32'h0000_0000, 1'b0, 1'b0, '0},
      '{32'hFFFF_FFFF, 1'b0, 1'b0, '0},
      // restart at the top, then flat: zero volatility holds the level
      '{32'hFFFF_FFFF, 1'b1, 1'b1, '{48'hFFFF_FFFF_0000, 48'hFFFF_FFFF_0000}},
      '{32'hFFFF_FFFF, 1'b0, 1'b1, '{48'hFFFF_FFFF_0000, 48'hFFFF_FFFF_0000}},
      '{32'hFFFF_FFFF, 1'b0, 1'b1, '{48'hFFFF_FFFF_0000, 48'hFFFF_FFFF_0000}},
      // clean downtrend: ratio saturates, alpha runs at the fast limit
      '{32'hFFFF_0000, 1'b0, 1'b0, '0},
      '{32'hFFFE_0000, 1'b0, 1'b0, '0},
      '{32'hFFFD_0000, 1'b0, 1'b0, '0},
      '{32'hFFFC_0000, 1'b0, 1'b0, '0},
      '{32'hFFFB_0000, 1'b0, 1'b0, '0},
      '{32'hFFFA_0000, 1'b0, 1'b0, '0},
      '{32'hFFF9_0000, 1'b0, 1'b0, '0},
      '{32'hFFF8_0000, 1'b0, 1'b0, '0},
      '{32'hFFF7_0000, 1'b0, 1'b0, '0},
      '{32'hFFF6_0000, 1'b0, 1'b0, '0},
      '{32'h1234_5678, 1'b0, 1'b0, '0},
      // restart mid-scale, then chop around it
      '{32'h8000_0000, 1'b1, 1'b1, '{48'h8000_0000_0000, 48'h8000_0000_0000}},
      '{32'h8000_0001, 1'b0, 1'b0, '0},
      '{32'h7FFF_FFFF, 1'b0, 1'b0, '0},
      '{32'h8000_0001, 1'b0, 1'b0, '0},
      '{32'h0000_0001, 1'b1, 1'b1, '{48'h0000_0001_0000, 48'h0000_0001_0000}}
   };

   limit_phase_type limit_phases [FIXED_PHASES] = '{
      '{16'h0000, 16'h0000, 1'b0},   // both limits below their floors
      '{16'hFFFF, 16'hFFFF, 1'b0},   // fast above ceiling, slow above fast
      '{FAST_MIN, FAST_MAX, 1'b1},   // slow pulled down to fast, no idling
      '{FAST_MAX, SLOW_MIN, 1'b0},   // widest legal span
      '{FAST_RESET, SLOW_RESET, 1'b0}
   };

   efficiency_ratio_adaptive_average_unit u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_close_price      (req_close_price),
      .req_restart          (req_restart),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_adaptive_average (rsp_adaptive_average),
      .rsp_follower_average (rsp_follower_average),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #(CLK_HALF) clock = ~clock;

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 4);
      if (roll < 98) return $urandom_range(5, 20);
      return $urandom_range(30, 80);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   // (w*x + (1-w)*y) in Q0.16 weights, truncated; split keeps it in 64 bits.
   function automatic logic [63:0] blend_q16(input logic [63:0] w, input logic [63:0] x,
                                             input logic [63:0] y);
      logic [63:0] w_rest, hi, lo;
      w_rest = 64'd65536 - w;
      hi     = w * (x >> 16) + w_rest * (y >> 16);
      lo     = w * (x & 64'hFFFF) + w_rest * (y & 64'hFFFF);
      return hi + (lo >> 16);
   endfunction

   // Advance the shadow series by one bar and return both averages.
   function automatic bar_result_type advance_series(input logic [PRICE_W-1:0] close,
                                                     input logic restart_bar);
      logic [63:0] close_fx, back_p, prev_p, change, move, ratio;
      logic [63:0] fast, slow, alpha;
      int unsigned pos;
      bar_result_type res;
      close_fx = {32'd0, close} << FRAC_W;
      if (!series_live || restart_bar) begin
         // seed: fill history with this close, clear the moves
         for (int i = 0; i < WINDOW; i++) begin
            close_ring[i] = close;
            move_ring[i]  = '0;
         end
         move_sum    = '0;
         kama_acc    = close_fx;
         follow_acc  = close_fx;
         series_live = 1'b1;
         ring_idx    = 1 % WINDOW;
      end else begin
         fast = 64'(fast_cfg);
         slow = 64'(slow_cfg);
         if (fast < 64'(FAST_MIN)) fast = 64'(FAST_MIN);
         if (fast > 64'(FAST_MAX)) fast = 64'(FAST_MAX);
         if (slow < 64'(SLOW_MIN)) slow = 64'(SLOW_MIN);
         if (slow > fast) slow = fast;

         pos    = ring_idx;
         back_p = 64'(close_ring[pos]);
         prev_p = 64'(close_ring[(pos + WINDOW - 1) % WINDOW]);
         change = (64'(close) >= back_p) ? 64'(close) - back_p : back_p - 64'(close);
         move   = (64'(close) >= prev_p) ? 64'(close) - prev_p : prev_p - 64'(close);

         move_sum        = move_sum - 64'(move_ring[pos]) + move;
         close_ring[pos] = close;
         move_ring[pos]  = move[PRICE_W-1:0];
         ring_idx        = (pos + 1) % WINDOW;

         // zero volatility gives a zero ratio, so alpha sits at the slow limit
         ratio = (move_sum == 0) ? 64'd0 : (change << 16) / move_sum;
         if (ratio > 64'(ER_ONE)) ratio = 64'(ER_ONE);

         alpha = slow + (((fast - slow) * ratio) >> 16);
         if (alpha < slow) alpha = slow;
         if (alpha > fast) alpha = fast;

         kama_acc   = blend_q16(alpha, close_fx, kama_acc);
         follow_acc = blend_q16(alpha >> 1, kama_acc, follow_acc);
      end
      res.adaptive = kama_acc[AVG_W-1:0];
      res.follower = follow_acc[AVG_W-1:0];
      return res;
   endfunction

   // Present one bar, hold it until the transfer, queue its expected result,
   // then idle for a random gap unless the phase runs steady.
   task automatic send_bar(input logic [PRICE_W-1:0] close, input logic restart_bar,
                           input logic typed, input bar_result_type known);
      bar_result_type predicted;
      int             gap;
      req_valid       <= 1'b1;
      req_close_price <= close;
      req_restart     <= restart_bar;
      do @(posedge clock); while (req_stall);
      predicted = advance_series(close, restart_bar);
      pending_results.push_back(typed ? known : predicted);
      gap = steady_flow ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Leave csr_valid high on return so back-to-back writes need no re-raise.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FAST_LIMIT: fast_cfg = data;
         CSR_SLOW_LIMIT: slow_cfg = data;
         default: ;
      endcase
   endtask

   task automatic wait_results_drained();
      int waited;
      waited = 0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_results.size() != 0) begin
         report_mismatch($sformatf("%0d bar results never arrived", pending_results.size()));
         pending_results.delete();
      end
   endtask

   // Receiver backpressure: segments of random length, each stalled by a one-in-three draw, never in a steady phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         rsp_stall  <= !steady_flow && ($urandom_range(0, 2) == 0);
         stall_hold <= pick_gap();
      end
   end

   // Check every result transfer against the oldest expected bar result.
   always @(posedge clock) begin
      bar_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result with no bar pending: avg %h fol %h",
                                      rsp_adaptive_average, rsp_follower_average));
         end else begin
            want = pending_results.pop_front();
            if (rsp_adaptive_average !== want.adaptive)
               report_mismatch($sformatf("adaptive_average got %h want %h",
                                         rsp_adaptive_average, want.adaptive));
            if (rsp_follower_average !== want.follower)
               report_mismatch($sformatf("follower_average got %h want %h",
                                         rsp_follower_average, want.follower));
         end
      end
   end

   initial begin
      logic [PRICE_W-1:0] walk_price;
      logic [LIMIT_W-1:0] fast_pick, slow_pick;
      logic               bar_restart;
      int                 trend_step, roll, scale, flat_left;

      walk_price = '0;
      flat_left  = 0;
      trend_step = 1;

      // Hold reset, then release it once for the whole run.
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table under the reset limits.
      foreach (directed_rows[r])
         send_bar(directed_rows[r].close, directed_rows[r].restart,
                  directed_rows[r].typed, directed_rows[r].known);
      req_valid <= 1'b0;
      wait_results_drained();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         // Pick the limits: fixed corners first, then random settings.
         if (phase < FIXED_PHASES) begin
            fast_pick   = limit_phases[phase].fast;
            slow_pick   = limit_phases[phase].slow;
            steady_flow = limit_phases[phase].steady;
         end else if (phase == FIXED_PHASES) begin
            fast_pick   = 16'($urandom);
            slow_pick   = 16'($urandom);
            steady_flow = 1'b0;
         end else begin
            fast_pick   = 16'($urandom_range(FAST_MIN, FAST_MAX));
            slow_pick   = 16'($urandom_range(SLOW_MIN, fast_pick));
            steady_flow = 1'b0;
         end

         // Block is idle here: write both limits, plus a write to a
         // reserved index that must leave them alone.
         write_csr(CSR_FAST_LIMIT, fast_pick);
         write_csr(CSR_SLOW_LIMIT, slow_pick);
         write_csr(phase[0] ? CSR_RSVD_HI : CSR_RSVD_LO, 16'($urandom));
         csr_valid <= 1'b0;

         trend_step = int'($urandom_range(1, 1 << $urandom_range(0, 16)));
         repeat (ITEMS_PER_PHASE) begin
            bar_restart = 1'b0;
            if (flat_left > 0) begin
               // hold the close: flat run drives volatility toward zero
               flat_left--;
            end else begin
               roll = $urandom_range(0, 99);
               if (roll < 3) begin
                  bar_restart = 1'b1;
                  walk_price  = $urandom;
               end else if (roll < 8) begin
                  walk_price = $urandom;
               end else if (roll < 14) begin
                  flat_left = $urandom_range(1, 14);
               end else if (roll < 17) begin
                  walk_price = $urandom_range(0, 1) ? '1 : '0;
               end else if (roll < 45) begin
                  walk_price = walk_price + trend_step;
               end else begin
                  scale      = $urandom_range(0, 20);
                  walk_price = walk_price + ($urandom_range(0, 1) ? 1 : -1) *
                               int'($urandom_range(0, 1 << scale));
               end
               if ($urandom_range(0, 39) == 0) trend_step = -trend_step;
            end
            send_bar(walk_price, bar_restart, 1'b0, '0);
         end
         req_valid <= 1'b0;
         wait_results_drained();
      end

      // Let any stray result show up before the verdict.
      repeat (LATENCY_PAD) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog: end a hung run.
   initial begin
      #(TIMEOUT_NS);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> efficiency_ratio_adaptive_average_unit.f
src/eraa_pkg.sv
src/eraa_ram.sv
src/efficiency_ratio_adaptive_average_unit.sv
test/efficiency_ratio_adaptive_average_unit_tb.sv
